[design/fault_ramp_power_limit_core_defines.svh]
// Assertion macros for the fault ramp power limiter.
// Used by the core; no other dependencies.
`ifndef FAULT_RAMP_POWER_LIMIT_CORE_DEFINES_SVH
`define FAULT_RAMP_POWER_LIMIT_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FRPL_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("frpl check failed");
// next-cycle implication
`define FRPL_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("frpl check failed");
`endif

[design/frpl_pkg.sv]
// Shared types and codes for the fault ramp power limiter.
// No dependencies.
package frpl_pkg;
    localparam int unsigned PWR_W  = 24;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned FRAC_W = 16;

    typedef enum logic [1:0] {
        REQ_RATED   = 2'd0,
        REQ_REDUCED = 2'd1,
        REQ_FAULT   = 2'd2,
        REQ_EVAL    = 2'd3
    } t_req;

    typedef enum logic [0:0] {
        CFG_RESTORE = 1'b0,
        CFG_RAMP    = 1'b1
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SLOT,
        ST_DIV,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_OUT,
        ST_EMIT
    } t_state;
endpackage

[design/fault_ramp_power_limit_core.sv]
// Fault ramp power limiter core: tables, sequencer and shared divide/multiply unit.
// Depends on frpl_pkg and fault_ramp_power_limit_core_defines.svh.
//
// Channel   Dir  Handshake        Payload
// in        in   valid / stall    req_type fault_slot thruster_sel power_value ...
// out       out  valid / stall    thruster_out power_available last_result
// cfg       in   valid / ready    index, data
//
// A load item is taken without stalling the input. An evaluation keeps the input
// stalled until its last result is presented; each fault whose window is open runs
// the 16-step restoring divider once and the one shared multiplier once per
// thruster, and result stalls lengthen the wait.
// Reset clears the rated table, fault times and flags; the reduced table is not cleared.
// A stalled result holds; the last result may still wait when the next item is taken.
`include "fault_ramp_power_limit_core_defines.svh"
module fault_ramp_power_limit_core #(
    parameter int THRUSTERS   = 8,
    parameter int FAULT_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_fault_slot,
    input  logic [2:0]  i_thruster_sel,
    input  logic [23:0] i_power_value,
    input  logic [31:0] i_time_value,
    input  logic        i_fault_active,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_thruster_out,
    output logic [23:0] o_power_available,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int TW = (THRUSTERS > 1) ? $clog2(THRUSTERS) : 1;
    localparam int SW = (FAULT_SLOTS > 1) ? $clog2(FAULT_SLOTS) : 1;
    localparam int TC = $clog2(THRUSTERS + 1);
    localparam int SC = $clog2(FAULT_SLOTS + 1);
    localparam int MW = (FAULT_SLOTS * THRUSTERS > 1) ? $clog2(FAULT_SLOTS * THRUSTERS) : 1;
    localparam int PW = frpl_pkg::PWR_W;
    localparam int FW = frpl_pkg::FRAC_W;

    assign o_cfg_ready = 1'b1;

    logic [31:0] r_restore, r_ramp;
    logic [PW-1:0] r_rated [THRUSTERS];
    logic [PW-1:0] r_lim [THRUSTERS];
    logic [31:0] r_ftime [FAULT_SLOTS];
    logic [FAULT_SLOTS-1:0] r_fvalid;
    logic [PW-1:0] r_reduced_mem [FAULT_SLOTS*THRUSTERS];

    frpl_pkg::t_state r_state, n_state;
    logic [31:0] r_tval;
    logic [SC-1:0] r_slot;
    logic [TC-1:0] r_thr;
    logic [4:0] r_step;
    logic [32:0] r_rem;           // divider partial remainder
    logic [FW-1:0] r_dividend;    // quotient bits shifted in
    logic [FW-1:0] r_frac;
    logic [PW-1:0] r_red, r_rat;
    logic [PW+FW-1:0] r_prod;
    logic r_up;
    logic [2:0] r_othr;
    logic [PW-1:0] r_opwr;
    logic r_olast, r_ovalid;

    logic in_acc;
    assign o_stall = (r_state != frpl_pkg::ST_IDLE);
    assign in_acc  = i_valid && !o_stall;

    logic [SW-1:0] slot_ix;
    logic [TW-1:0] thr_ix;
    assign slot_ix = r_slot[SW-1:0];
    assign thr_ix  = r_thr[TW-1:0];

    logic [MW-1:0] wr_addr, rd_addr;
    assign wr_addr = MW'(32'(i_fault_slot) * 32'(THRUSTERS) + 32'(i_thruster_sel));
    assign rd_addr = MW'(32'(slot_ix) * 32'(THRUSTERS) + 32'(thr_ix));

    // window check for current slot
    logic [31:0] ft, elapsed;
    logic [32:0] win_end;
    logic in_win;
    always_comb begin
        ft      = r_ftime[slot_ix];
        elapsed = r_tval - ft;
        win_end = {1'b0, r_restore} + {1'b0, r_ramp};
        in_win  = r_fvalid[slot_ix] && (r_tval >= ft) && (elapsed >= r_restore)
                  && ({1'b0, elapsed} < win_end);
    end

    logic [32:0] sub_try;
    assign sub_try = {r_rem[31:0], 1'b0} - {1'b0, r_ramp};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            frpl_pkg::ST_IDLE:
                if (in_acc && i_req_type == frpl_pkg::REQ_EVAL) n_state = frpl_pkg::ST_INIT;
            frpl_pkg::ST_INIT:
                if (r_thr == TC'(THRUSTERS - 1)) n_state = frpl_pkg::ST_SLOT;
            frpl_pkg::ST_SLOT:
                if (r_slot == SC'(FAULT_SLOTS)) n_state = frpl_pkg::ST_OUT;
                else if (in_win) n_state = frpl_pkg::ST_DIV;
            frpl_pkg::ST_DIV:
                if (r_step == 5'd15) n_state = frpl_pkg::ST_RD;
            frpl_pkg::ST_RD:  n_state = frpl_pkg::ST_MUL;
            frpl_pkg::ST_MUL: n_state = frpl_pkg::ST_ACC;
            frpl_pkg::ST_ACC:
                if (r_thr == TC'(THRUSTERS - 1)) n_state = frpl_pkg::ST_SLOT;
                else n_state = frpl_pkg::ST_RD;
            frpl_pkg::ST_OUT:
                if (!r_ovalid || !i_stall) n_state = frpl_pkg::ST_EMIT;
            frpl_pkg::ST_EMIT:
                if (r_thr == TC'(THRUSTERS - 1)) n_state = frpl_pkg::ST_IDLE;
                else n_state = frpl_pkg::ST_OUT;
            default: n_state = frpl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= frpl_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    // memory port: written on load, read in ST_RD
    always_ff @(posedge i_clk) begin
        if (in_acc && i_req_type == frpl_pkg::REQ_REDUCED
            && 32'(i_fault_slot) < 32'(FAULT_SLOTS) && 32'(i_thruster_sel) < 32'(THRUSTERS))
            r_reduced_mem[wr_addr] <= i_power_value;
        if (r_state == frpl_pkg::ST_RD)
            r_red <= r_reduced_mem[rd_addr];
    end

    logic [PW-1:0] diff;
    assign diff = (r_rat >= r_red) ? (r_rat - r_red) : (r_red - r_rat);
    logic [PW-1:0] step_v, cand;
    assign step_v = r_prod[PW+FW-1:FW];
    assign cand = r_up ? (r_red + step_v) : (r_red - step_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restore <= 32'd0;
            r_ramp    <= 32'd10000;
            r_fvalid  <= '0;
            r_ovalid  <= 1'b0;
            for (int k = 0; k < THRUSTERS; k++) r_rated[k] <= '0;
            for (int k = 0; k < FAULT_SLOTS; k++) r_ftime[k] <= '0;
            r_thr  <= '0;
            r_slot <= '0;
            r_step <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (frpl_pkg::t_cfg'(i_cfg_index))
                    frpl_pkg::CFG_RESTORE: r_restore <= i_cfg_data;
                    frpl_pkg::CFG_RAMP:    r_ramp    <= i_cfg_data;
                    default: ;
                endcase
            end
            // drop a taken result unless the next one loads in its place
            if (r_ovalid && !i_stall && r_state != frpl_pkg::ST_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                frpl_pkg::ST_IDLE: begin
                    r_thr  <= '0;
                    r_slot <= '0;
                    r_tval <= i_time_value;
                    if (in_acc) begin
                        case (frpl_pkg::t_req'(i_req_type))
                            frpl_pkg::REQ_RATED:
                                if (32'(i_thruster_sel) < 32'(THRUSTERS))
                                    r_rated[TW'(i_thruster_sel)] <= i_power_value;
                            frpl_pkg::REQ_FAULT:
                                if (32'(i_fault_slot) < 32'(FAULT_SLOTS)) begin
                                    r_ftime[SW'(i_fault_slot)]  <= i_time_value;
                                    r_fvalid[SW'(i_fault_slot)] <= i_fault_active;
                                end
                            default: ;
                        endcase
                    end
                end
                frpl_pkg::ST_INIT: begin
                    r_lim[thr_ix] <= r_rated[thr_ix];
                    r_thr <= (r_thr == TC'(THRUSTERS - 1)) ? '0 : r_thr + 1'b1;
                end
                frpl_pkg::ST_SLOT: begin
                    r_step <= '0;
                    r_rem  <= {1'b0, elapsed - r_restore};
                    r_thr  <= '0;
                    r_dividend <= '0;
                    if (r_slot != SC'(FAULT_SLOTS) && !in_win) r_slot <= r_slot + 1'b1;
                end
                frpl_pkg::ST_DIV: begin
                    // one restoring divide step per cycle; the remainder starts below
                    // ramp, so 16 steps give the whole fraction
                    r_dividend <= {r_dividend[FW-2:0], !sub_try[32]};
                    r_rem <= sub_try[32] ? {r_rem[31:0], 1'b0} : sub_try;
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd15) r_frac <= {r_dividend[FW-2:0], !sub_try[32]};
                end
                frpl_pkg::ST_RD: begin
                    r_rat <= r_rated[thr_ix];
                end
                frpl_pkg::ST_MUL: begin
                    r_up   <= r_rat >= r_red;
                    r_prod <= diff * r_frac;
                end
                frpl_pkg::ST_ACC: begin
                    if (cand < r_lim[thr_ix]) r_lim[thr_ix] <= cand;
                    if (r_thr == TC'(THRUSTERS - 1)) begin
                        r_thr  <= '0;
                        r_slot <= r_slot + 1'b1;
                    end else r_thr <= r_thr + 1'b1;
                end
                frpl_pkg::ST_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_othr   <= 3'(r_thr);
                        r_opwr   <= r_lim[thr_ix];
                        r_olast  <= (r_thr == TC'(THRUSTERS - 1));
                    end
                end
                frpl_pkg::ST_EMIT: begin
                    r_thr <= (r_thr == TC'(THRUSTERS - 1)) ? '0 : r_thr + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_thruster_out    = r_othr;
    assign o_power_available = r_opwr;
    assign o_last_result     = r_olast;

    `FRPL_ASSERT_IMP(a_busy_no_accept, i_clk, i_rst_n, r_state != frpl_pkg::ST_IDLE, o_stall)
    `FRPL_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_power_available))
    `FRPL_ASSERT_IMP(a_last_at_end, i_clk, i_rst_n, o_valid && o_last_result, o_thruster_out == 3'(THRUSTERS - 1))
endmodule
